@@ rtl/core/msb_first_bit_packer_unpacker_core_macros.svh @@
// Assertion helpers for the bit packer core.
`ifndef MSB_FIRST_BIT_PACKER_UNPACKER_CORE_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_UNPACKER_CORE_MACROS_SVH

// same-cycle implication
`define MSBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/msbp_pkg.sv @@
package msbp_pkg;

  localparam int BUFFER_BYTES_DEF = 256;
  localparam int CURSOR_W         = 16;
  localparam int DATA_W           = 32;
  localparam int CAP_W            = 9;
  localparam int CAP_BITS_W       = 12;
  localparam int WIDTH_W          = 6;
  localparam int BIDX_W           = 11;
  localparam int CAP_FIELD_MAX    = 511;

  localparam logic [CURSOR_W-1:0] CURSOR_MAX = 16'hFFFF;
  localparam logic [WIDTH_W-1:0]  MAX_WIDTH  = 6'd32;

  // register map index (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_WRITABLE = 1'b1;

  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_READ_U   = 3'd1,
    OP_READ_S   = 3'd2,
    OP_ALIGN    = 3'd3,
    OP_SET_BIT  = 3'd4,
    OP_RESTART  = 3'd5
  } op_e;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic                ok;
    logic [DATA_W-1:0]   rdata;
    logic                we;
    logic [DATA_W-1:0]   even_wd;
    logic [DATA_W-1:0]   odd_wd;
  } exec_res_t;

endpackage

@@ rtl/core/msbp_bank.sv @@
module msbp_bank #(
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [2**AW];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/msbp_exec.sv @@
module msbp_exec (
  input  logic [2:0]                              op_i,
  input  logic [msbp_pkg::DATA_W-1:0]             value_i,
  input  logic [msbp_pkg::WIDTH_W-1:0]            width_i,
  input  logic [msbp_pkg::BIDX_W-1:0]             bit_index_i,
  input  logic                                    bit_value_i,
  input  logic [msbp_pkg::CURSOR_W-1:0]           cursor_i,
  input  logic                                    ok_i,
  input  logic [msbp_pkg::CAP_BITS_W-1:0]         cap_bits_i,
  input  logic                                    writable_i,
  input  logic [msbp_pkg::DATA_W-1:0]             even_rd_i,
  input  logic [msbp_pkg::DATA_W-1:0]             odd_rd_i,
  output msbp_pkg::exec_res_t                     res_o
);
  import msbp_pkg::*;

  op_e                 op;
  logic [CURSOR_W-1:0] pos;
  logic [WIDTH_W-1:0]  n;
  logic [DATA_W-1:0]   wval;
  logic [4:0]          ofs;
  logic [6:0]          sh;
  logic [63:0]         win;
  logic [63:0]         new_win;
  logic [63:0]         mask64;
  logic [DATA_W-1:0]   lowmask;
  logic [DATA_W-1:0]   raw;
  logic [DATA_W-1:0]   sext;
  logic                bad_w;
  logic [16:0]         sum;
  logic [16:0]         cap17;
  logic                over;
  logic [16:0]         aligned;

  always_comb begin
    op    = op_e'(op_i);
    pos   = (op == OP_SET_BIT) ? {{(CURSOR_W-BIDX_W){1'b0}}, bit_index_i} : cursor_i;
    n     = (op == OP_SET_BIT) ? WIDTH_W'(1) : width_i;
    wval  = (op == OP_SET_BIT) ? {{(DATA_W-1){1'b0}}, bit_value_i} : value_i;
    ofs   = pos[4:0];
    // window: word holding pos in the upper half, next word below
    win   = pos[5] ? {odd_rd_i, even_rd_i} : {even_rd_i, odd_rd_i};
    sh    = 7'd64 - {2'b00, ofs} - {1'b0, n};
    lowmask = 32'hFFFF_FFFF >> (MAX_WIDTH - n);
    raw   = DATA_W'(win >> sh) & lowmask;
    sext  = raw;
    if ((op == OP_READ_S) && (n != MAX_WIDTH) && ((raw & ~(lowmask >> 1)) != '0)) begin
      sext = raw | ~lowmask;
    end
    mask64  = {32'b0, lowmask} << sh;
    new_win = (win & ~mask64) | (({32'b0, wval} << sh) & mask64);

    bad_w   = (width_i == '0) || (width_i > MAX_WIDTH);
    sum     = {1'b0, cursor_i} + {11'b0, width_i};
    cap17   = {5'b0, cap_bits_i};
    over    = sum > cap17;
    aligned = {({1'b0, cursor_i[CURSOR_W-1:3]} + 14'd1), 3'b000};

    res_o.cursor  = cursor_i;
    res_o.ok      = ok_i;
    res_o.rdata   = '0;
    res_o.we      = 1'b0;
    res_o.even_wd = pos[5] ? new_win[31:0] : new_win[63:32];
    res_o.odd_wd  = pos[5] ? new_win[63:32] : new_win[31:0];

    case (op)
      OP_WRITE: begin
        if (!writable_i || bad_w) begin
          res_o.ok = 1'b0;
        end else if (over) begin
          res_o.ok     = 1'b0;
          res_o.cursor = (sum > {1'b0, CURSOR_MAX}) ? CURSOR_MAX : sum[CURSOR_W-1:0];
        end else begin
          res_o.we     = 1'b1;
          res_o.cursor = sum[CURSOR_W-1:0];
        end
      end
      OP_READ_U, OP_READ_S: begin
        if (bad_w || over) begin
          res_o.ok = 1'b0;
        end else begin
          res_o.rdata  = sext;
          res_o.cursor = sum[CURSOR_W-1:0];
        end
      end
      OP_ALIGN: begin
        if (cursor_i[2:0] != 3'd0) begin
          if (aligned > cap17) begin
            res_o.ok     = 1'b0;
            res_o.cursor = {{(CURSOR_W-CAP_BITS_W){1'b0}}, cap_bits_i};
          end else begin
            res_o.cursor = aligned[CURSOR_W-1:0];
          end
        end
      end
      OP_SET_BIT: begin
        if (!writable_i || ({1'b0, bit_index_i} >= cap_bits_i)) begin
          res_o.ok = 1'b0;
        end else begin
          res_o.we = 1'b1;
        end
      end
      OP_RESTART: begin
        res_o.cursor = '0;
        res_o.ok     = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/msb_first_bit_packer_unpacker_core.sv @@
// Channel   Dir  Payload
// s_axis    in   tuser: operation; tdata: value, width, bit_index, bit_value
// m_axis    out  tuser: stream_valid; tdata: read_data, bit_position
// apb       in   usable buffer size in bytes at 0x0, writable at 0x4
//
// For each item, at accept both word banks are read at the access position; in
// execute the 64-bit window is modified and written back while the result is
// registered.
// After reset a clearing pass zeroes every word of both banks, with tready low.
// A stalled result holds in the output register; one more item may be accepted
// meanwhile and waits in execute until the result is taken.
`include "msb_first_bit_packer_unpacker_core_macros.svh"

module msb_first_bit_packer_unpacker_core #(
  parameter int BUFFER_BYTES = msbp_pkg::BUFFER_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // value[31:0], width[37:32], bit_index[48:38], bit_value[49]
  input  logic [2:0]  s_axis_tuser,   // operation[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // read_data[31:0], bit_position[47:32]
  output logic [0:0]  m_axis_tuser,   // stream_valid[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import msbp_pkg::*;

  localparam int NUM_WORDS = (BUFFER_BYTES + 3) / 4;
  localparam int BANK_DEPTH = NUM_WORDS / 2 + 1;
  localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int CAP_LIM_I = (BUFFER_BYTES > CAP_FIELD_MAX) ? CAP_FIELD_MAX : BUFFER_BYTES;
  localparam logic [CAP_W-1:0] CAP_LIM = CAP_W'(CAP_LIM_I);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [BAW-1:0]      clr_q;
  logic [CAP_W-1:0]    cap_q;
  logic                writable_q;
  logic [CURSOR_W-1:0] cursor_q;
  logic                ok_q;

  logic [2:0]          op_q;
  logic [DATA_W-1:0]   value_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [BIDX_W-1:0]   bidx_q;
  logic                bval_q;
  logic [BAW-1:0]      ea_q, oa_q;

  logic                m_valid_q;
  logic [DATA_W-1:0]   m_rdata_q;
  logic [CURSOR_W-1:0] m_pos_q;
  logic                m_ok_q;

  logic                accept;
  logic                done;
  logic                cfg_we;
  logic [CURSOR_W-1:0] rd_pos;
  logic [11:0]         word_x;
  logic [11:0]         word_p1;
  logic [BAW-1:0]      ea, oa;
  logic [CAP_W-1:0]    cap_eff;
  logic [CAP_BITS_W-1:0] cap_bits;
  logic                bank_we;
  logic [BAW-1:0]      even_waddr, odd_waddr;
  logic [31:0]         even_wdata, odd_wdata;
  logic [31:0]         even_rd, odd_rd;
  exec_res_t           res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_WRITABLE) ? {31'b0, writable_q}
                                             : {{(32-CAP_W){1'b0}}, cap_q};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign done   = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

  // word pair around the access position: word w and w+1 sit in opposite banks
  always_comb begin
    rd_pos  = (op_e'(s_axis_tuser) == OP_SET_BIT)
            ? {{(CURSOR_W-BIDX_W){1'b0}}, s_axis_tdata[48:38]} : cursor_q;
    word_x  = {1'b0, rd_pos[CURSOR_W-1:5]};
    word_p1 = word_x + 12'd1;
    ea      = word_p1[BAW:1];
    oa      = word_x[BAW:1];
  end

  always_comb begin
    cap_eff  = (cap_q > CAP_LIM) ? CAP_LIM : cap_q;
    cap_bits = {cap_eff, 3'b000};
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == {BAW{1'b1}}) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_EXEC;
      ST_EXEC:  if (done) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      cap_q      <= 9'd256;
      writable_q <= 1'b1;
      cursor_q   <= '0;
      ok_q       <= 1'b1;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + BAW'(1);
      end
      if (cfg_we) begin
        if (paddr[2] == REG_CAPACITY) begin
          cap_q <= pwdata[CAP_W-1:0];
        end else begin
          writable_q <= pwdata[0];
        end
      end
      if (done) begin
        cursor_q  <= res.cursor;
        ok_q      <= res.ok;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= s_axis_tuser;
      value_q <= s_axis_tdata[31:0];
      width_q <= s_axis_tdata[37:32];
      bidx_q  <= s_axis_tdata[48:38];
      bval_q  <= s_axis_tdata[49];
      ea_q    <= ea;
      oa_q    <= oa;
    end
    if (done) begin
      m_rdata_q <= res.rdata;
      m_pos_q   <= res.cursor;
      m_ok_q    <= res.ok;
    end
  end

  assign bank_we    = (state_q == ST_CLEAR) || (done && res.we);
  assign even_waddr = (state_q == ST_CLEAR) ? clr_q : ea_q;
  assign odd_waddr  = (state_q == ST_CLEAR) ? clr_q : oa_q;
  assign even_wdata = (state_q == ST_CLEAR) ? 32'b0 : res.even_wd;
  assign odd_wdata  = (state_q == ST_CLEAR) ? 32'b0 : res.odd_wd;

  msbp_bank #(.AW(BAW)) u_even (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .waddr_i (even_waddr),
    .wdata_i (even_wdata),
    .re_i    (accept),
    .raddr_i (ea),
    .rdata_o (even_rd)
  );

  msbp_bank #(.AW(BAW)) u_odd (
    .clk_i   (clk_i),
    .we_i    (bank_we),
    .waddr_i (odd_waddr),
    .wdata_i (odd_wdata),
    .re_i    (accept),
    .raddr_i (oa),
    .rdata_o (odd_rd)
  );

  msbp_exec u_exec (
    .op_i        (op_q),
    .value_i     (value_q),
    .width_i     (width_q),
    .bit_index_i (bidx_q),
    .bit_value_i (bval_q),
    .cursor_i    (cursor_q),
    .ok_i        (ok_q),
    .cap_bits_i  (cap_bits),
    .writable_i  (writable_q),
    .even_rd_i   (even_rd),
    .odd_rd_i    (odd_rd),
    .res_o       (res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_pos_q, m_rdata_q};
  assign m_axis_tuser  = m_ok_q;

  `MSBP_ASSERT_NEXT(a_accept_to_exec, accept, state_q == ST_EXEC, "accept did not start execute")
  `MSBP_ASSERT_NOW(a_result_from_exec, $rose(m_valid_q), $past(state_q == ST_EXEC), "result without execute")
  `MSBP_ASSERT_NOW(a_cursor_on_done, cursor_q != $past(cursor_q), $past(done), "cursor moved outside completion")
  `MSBP_ASSERT_NOW(a_bank_write_phase, bank_we, (state_q == ST_EXEC) || (state_q == ST_CLEAR), "bank write while idle")

endmodule

@@ tb/msb_first_bit_packer_unpacker_core_test.sv @@
module msb_first_bit_packer_unpacker_core_test;
  import msbp_pkg::*;

  localparam int BUF_BYTES      = BUFFER_BYTES_DEF;
  localparam int DRAIN_CYCLES   = 8;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] rd;
    logic        ok;
    logic [15:0] pos;
  } result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // value[31:0], width[37:32], bit_index[48:38], bit_value[49]
  logic [2:0]  s_axis_tuser = '0;   // operation[2:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // read_data[31:0], bit_position[47:32]
  logic [0:0]  m_axis_tuser;        // stream_valid[0]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  msb_first_bit_packer_unpacker_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the packer state
  logic [7:0]  bit_store [0:BUF_BYTES-1];
  int unsigned bit_cursor;
  bit          stream_ok;
  int unsigned cap_bytes;
  bit          store_writable;

  result_t     pending_results [$];
  int          n_errors;
  int          n_sent;
  int          n_results;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  bit          hold_req;
  int          hold_left;
  int          stall_cycles;

  function automatic int unsigned capacity_in_bits();
    return ((cap_bytes > BUF_BYTES) ? BUF_BYTES : cap_bytes) * 8;
  endfunction

  function automatic void store_bit(int unsigned p, bit b);
    bit_store[(p >> 3) % BUF_BYTES][7 - (p % 8)] = b;
  endfunction

  function automatic bit fetch_bit(int unsigned p);
    return bit_store[(p >> 3) % BUF_BYTES][7 - (p % 8)];
  endfunction

  function automatic result_t apply_op(op_e op, logic [31:0] val, logic [5:0] width,
                                       logic [10:0] bidx, logic bval);
    result_t     r;
    int unsigned w;
    int unsigned cap;
    int unsigned pad;
    logic [31:0] acc;
    w   = 32'(width);
    cap = capacity_in_bits();
    acc = '0;
    case (op)
      OP_WRITE: begin
        if (w >= 1 && w < 32) val = val & ((32'd1 << w) - 32'd1);
        if (!store_writable || w == 0 || w > 32) begin
          stream_ok = 1'b0;
        end else if (bit_cursor + w > cap) begin
          // overrun still moves the cursor, saturating at the top
          stream_ok = 1'b0;
          bit_cursor += w;
          if (bit_cursor > 32'hFFFF) bit_cursor = 32'hFFFF;
        end else begin
          for (int i = w; i > 0; i--) begin
            store_bit(bit_cursor, val[i-1]);
            bit_cursor++;
          end
        end
      end
      OP_READ_U, OP_READ_S: begin
        if (w == 0 || w > 32 || bit_cursor + w > cap) begin
          stream_ok = 1'b0;
        end else begin
          for (int i = 0; i < w; i++) begin
            acc = {acc[30:0], fetch_bit(bit_cursor)};
            bit_cursor++;
          end
          if (op == OP_READ_S && w < 32 && acc[w-1]) acc = acc | ~((32'd1 << w) - 32'd1);
        end
      end
      OP_ALIGN: begin
        if (bit_cursor % 8 != 0) begin
          pad = 8 - bit_cursor % 8;
          if (bit_cursor + pad > cap) begin
            stream_ok  = 1'b0;
            bit_cursor = cap;
          end else begin
            bit_cursor += pad;
          end
        end
      end
      OP_SET_BIT: begin
        if (!store_writable || bidx >= cap) stream_ok = 1'b0;
        else store_bit(32'(bidx), bval);
      end
      OP_RESTART: begin
        bit_cursor = 0;
        stream_ok  = 1'b1;
      end
      default: ;
    endcase
    r.rd  = acc;
    r.ok  = stream_ok;
    r.pos = bit_cursor[15:0];
    return r;
  endfunction

  task automatic log_mismatch(string msg);
    n_errors++;
    if (n_errors <= 10) $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) log_mismatch($sformatf("%s expected %h got %h", name, want, got));
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("result with nothing pending, tdata %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        check_field("read_data", want.rd, m_axis_tdata[31:0]);
        check_field("stream_valid", 32'(want.ok), 32'(m_axis_tuser[0]));
        check_field("bit_position", 32'(want.pos), 32'(m_axis_tdata[47:32]));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("msb_first_bit_packer_unpacker_core test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_op(op_e op, logic [31:0] val = '0, logic [5:0] width = '0,
                         logic [10:0] bidx = '0, logic bval = 1'b0);
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {6'd0, bval, bidx, width, val};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_op(op, val, width, bidx, bval));
    n_sent++;
  endtask

  // stop offering and let every pending result come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic reg_sel, logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == REG_CAPACITY) cap_bytes = 32'(data[8:0]);
    else store_writable = data[0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int unsigned cap, bit wr);
    drain();
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_WRITABLE, 32'(wr));
  endtask

  function automatic logic [10:0] rand_bit_index();
    int unsigned lim;
    lim = capacity_in_bits();
    if (lim > 2047) lim = 2047;
    return 11'($urandom_range(lim));
  endfunction

  task automatic test_basic_ops();
    configure(256, 1'b1);
    send_op(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_op(OP_WRITE, 32'hFFFF_FFFE, 6'd1);      // only the low bit counts
    send_op(OP_WRITE, 32'hABCD_EF55, 6'd7);
    send_op(OP_WRITE, 32'h1234_5678, 6'd0);
    send_op(OP_WRITE, 32'h1234_5678, 6'd33);
    send_op(OP_WRITE, 32'h0, 6'd63, 11'h7FF, 1'b1);
    send_op(OP_RESTART, 32'hFFFF_FFFF, 6'd63, 11'h7FF, 1'b1);
    send_op(OP_READ_U, 32'hFFFF_FFFF, 6'd32);
    send_op(OP_READ_S, 32'h0, 6'd1);
    send_op(OP_READ_S, 32'h0, 6'd7);             // negative, gets sign-extended
    send_op(OP_ALIGN);                           // already on a byte boundary
    send_op(OP_READ_U, 32'h0, 6'd3);
    send_op(OP_ALIGN);
    send_op(OP_READ_U, 32'h0, 6'd0);
    send_op(OP_READ_S, 32'h0, 6'd63);
    send_op(OP_READ_S, 32'h0, 6'd32);
    send_op(OP_SET_BIT, 32'h0, 6'd0, 11'd0, 1'b0);
    send_op(OP_SET_BIT, 32'h0, 6'd0, 11'd2047, 1'b1);
    send_op(OP_SET_BIT, 32'h0, 6'd0, 11'd9, 1'b1);
    send_op(OP_RESTART);
    send_op(OP_READ_S, 32'h0, 6'd16);
    send_op(OP_RESTART);
  endtask

  task automatic test_overruns();
    configure(1, 1'b1);
    send_op(OP_WRITE, 32'h1F, 6'd5);
    send_op(OP_ALIGN);
    send_op(OP_READ_U, 32'h0, 6'd1);             // read past the end
    send_op(OP_RESTART);
    send_op(OP_WRITE, 32'h55, 6'd7);
    send_op(OP_WRITE, 32'h7, 6'd3);              // write past the end
    send_op(OP_ALIGN);                           // pulls the cursor back to capacity
    send_op(OP_SET_BIT, 32'h0, 6'd0, 11'd8, 1'b1);
    send_op(OP_SET_BIT, 32'h0, 6'd0, 11'd7, 1'b1);
    send_op(OP_RESTART);
    send_op(OP_READ_S, 32'h0, 6'd8);
    send_op(OP_READ_U, 32'h0, 6'd9);
    configure(0, 1'b1);
    send_op(OP_RESTART);
    send_op(OP_READ_U, 32'h0, 6'd1);
    send_op(OP_ALIGN);
    send_op(OP_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_op(OP_WRITE, 32'h5, 6'd3);
    send_op(OP_ALIGN);
    configure(256, 1'b0);
    send_op(OP_RESTART);
    send_op(OP_WRITE, 32'hA5, 6'd8);             // refused on a read-only stream
    send_op(OP_SET_BIT, 32'h0, 6'd0, 11'd3, 1'b1);
    send_op(OP_RESTART);
    send_op(OP_READ_U, 32'h0, 6'd24);
  endtask

  // overrunning writes keep pushing the cursor far past capacity
  task automatic test_overrun_advance();
    configure(0, 1'b1);
    send_op(OP_RESTART);
    repeat (40) send_op(OP_WRITE, $urandom, 6'($urandom_range(32, 1)));
    send_op(OP_ALIGN);
    send_op(OP_WRITE, $urandom, 6'd31);
    send_op(OP_ALIGN);
    send_op(OP_READ_U, $urandom, 6'd1);
    send_op(OP_RESTART);
  endtask

  // sender keeps offering while the receiver holds off, so the core backs up
  task automatic test_output_backpressure();
    configure(256, 1'b1);
    hold_req = 1'b1;
    repeat (30) send_op(op_e'($urandom_range(OP_RESTART)), $urandom,
                        6'($urandom_range(32, 1)), rand_bit_index(),
                        1'($urandom_range(1)));
    drain();
  endtask

  task automatic run_traffic(int n_items);
    int          first;
    int          kind;
    int          pick;
    int unsigned w;
    int unsigned layout [$];
    first = n_sent;
    while (n_sent - first < n_items) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        // write a record of random fields, rewind and read it back
        layout.delete();
        if (kind < 65) send_op(OP_RESTART, $urandom, 6'($urandom), 11'($urandom),
                               1'($urandom));
        repeat ($urandom_range(40, 1)) begin
          pick = $urandom_range(15);
          if (pick == 0) begin
            layout.push_back(0);
            send_op(OP_ALIGN, $urandom, 6'($urandom));
          end else if (pick == 1) begin
            send_op(OP_SET_BIT, $urandom, 6'($urandom), rand_bit_index(),
                    1'($urandom_range(1)));
          end else begin
            w = $urandom_range(32, 1);
            layout.push_back(w);
            send_op(OP_WRITE, $urandom, 6'(w));
          end
        end
        send_op(OP_RESTART, $urandom, 6'($urandom));
        foreach (layout[i]) begin
          if (layout[i] == 0) begin
            send_op(OP_ALIGN);
          end else begin
            w = ($urandom_range(7) == 0) ? $urandom_range(32, 1) : layout[i];
            send_op($urandom_range(1) ? OP_READ_S : OP_READ_U, $urandom, 6'(w));
          end
        end
      end else begin
        repeat ($urandom_range(8, 1))
          send_op(op_e'($urandom_range(OP_RESTART)), $urandom, 6'($urandom_range(63)),
                  11'($urandom_range(2047)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic test_random_traffic();
    snd_idle_pct = 24;
    rcv_idle_pct = 50;
    configure(256, 1'b1);
    run_traffic(400);
    snd_idle_pct = 50;
    rcv_idle_pct = 24;
    configure($urandom_range(64, 1), 1'b1);
    run_traffic(400);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    configure($urandom_range(256, 1), 1'b1);
    run_traffic(200);
    configure($urandom_range(256, 1), 1'b0);
    run_traffic(80);
    configure(256, 1'b1);
    run_traffic(40);
  endtask

  initial begin
    foreach (bit_store[i]) bit_store[i] = 8'h00;
    bit_cursor     = 0;
    stream_ok      = 1'b1;
    cap_bytes      = 256;
    store_writable = 1'b1;
    n_errors       = 0;
    n_sent         = 0;
    n_results      = 0;
    snd_idle_pct   = 24;
    rcv_idle_pct   = 50;
    hold_req       = 1'b0;
    hold_left      = 0;
    stall_cycles   = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_ops();
    test_overruns();
    test_overrun_advance();
    test_output_backpressure();
    test_random_traffic();
    drain();

    n_errors += pending_results.size();
    $display("covered %0d transfers in, %0d out: all operations, bad widths, overruns,",
             n_sent, n_results);
    $display("capacities 0 to 256, read-only stream, long output stall");
    if (n_errors == 0) begin
      $display("msb_first_bit_packer_unpacker_core test passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("msb_first_bit_packer_unpacker_core test failed");
    end
    $finish;
  end

endmodule
